// File: src/rbfks_pkg.sv
// shared types and constants of the rbf kernel classifier score block
package rbfks_pkg;

  localparam int DEF_MAX_VECTORS     = 64;
  localparam int DEF_MAX_FEATURES    = 16;
  localparam int DEF_EXP_TABLE_DEPTH = 256;

  localparam int D2_W     = 38;  // squared distance, up to 64 features of 17-bit diffs
  localparam int WEIGHT_W = 24;
  localparam int SCALE_W  = 16;
  localparam int GAMMA_W  = 16;
  localparam int EXP_W    = 17;  // table entries, unsigned Q1.16
  localparam int ACC_W    = 52;  // weighted kernel sum, Q.32
  localparam int FRAC_W   = 20;  // interpolation fraction

  typedef enum logic [1:0] {
    REQ_COORD  = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_SAMPLE = 2'd2
  } rbfks_req_t;

  typedef enum logic [2:0] {
    REG_SV_COUNT = 3'd0,
    REG_DIM      = 3'd1,
    REG_GAMMA    = 3'd2,
    REG_BIAS     = 3'd3,
    REG_INVERT   = 3'd4
  } rbfks_reg_t;

  // one finished distance with the vector's weight and scale
  typedef struct packed {
    logic                       valid;
    logic                       last;
    logic [D2_W-1:0]            d2;
    logic [SCALE_W-1:0]         scale;
    logic signed [WEIGHT_W-1:0] weight;
  } rbfks_vec_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] sum;
  } rbfks_sum_t;

endpackage

// File: src/rbf_kernel_classifier_score_top.sv
// top level of the rbf kernel classifier score block
//
// Input beats load the tables and the sample: tuser 0 writes one vector
// coordinate, tuser 1 a vector's weight and scale, tuser 2 a sample feature.
// Table writes and features without tlast are taken back to back while the
// block is idle. A feature with tlast starts the score: the sample sits in a
// ring of feature cells that rotates once per cycle while the coordinate
// memory streams one coordinate per cycle into the distance, kernel and
// rounding pipeline; the input is not ready meanwhile. With no active
// vectors the score is the negated or plain bias.
// The score beat waits in an output register; while the receiver stalls, a
// following score waits finished inside the block and the input stays not
// ready until the output register frees up.
// Reset returns the registers to their reset values; table contents stay
// undefined until written. The user must write configuration over the APB
// port only while no score is in flight; the block does not enforce this.
module rbf_kernel_classifier_score_top
  import rbfks_pkg::*;
#(
  parameter int MAX_VECTORS     = DEF_MAX_VECTORS,
  parameter int MAX_FEATURES    = DEF_MAX_FEATURES,
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // apb configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // sv_index[5:0], feature_index[9:6], value[25:10], alpha[49:26], beta[65:50], zero
  input  logic [71:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // score[31:0]
  output logic [31:0] out_tdata,
  // saturated[0]
  output logic        out_tuser
);

  localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int VIW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int CDEPTH = MAX_VECTORS * MAX_FEATURES;
  localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int NSW = $clog2(MAX_VECTORS + 1);
  localparam int DMW = $clog2(MAX_FEATURES + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_HOLD} state_t;

  // configuration registers
  logic [6:0]  sv_count_r;
  logic [4:0]  dim_r;
  logic [15:0] gamma_r;
  logic [31:0] bias_r;
  logic        invert_r;
  logic        cfg_wr;
  rbfks_reg_t  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = rbfks_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_count_r <= 7'd0;
      dim_r      <= 5'd2;
      gamma_r    <= 16'd410;
      bias_r     <= 32'd0;
      invert_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SV_COUNT: sv_count_r <= cfg_pwdata[6:0];
        REG_DIM:      dim_r      <= cfg_pwdata[4:0];
        REG_GAMMA:    gamma_r    <= cfg_pwdata[15:0];
        REG_BIAS:     bias_r     <= cfg_pwdata;
        REG_INVERT:   invert_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SV_COUNT: cfg_prdata = {25'd0, sv_count_r};
      REG_DIM:      cfg_prdata = {27'd0, dim_r};
      REG_GAMMA:    cfg_prdata = {16'd0, gamma_r};
      REG_BIAS:     cfg_prdata = bias_r;
      REG_INVERT:   cfg_prdata = {31'd0, invert_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // input beat fields
  logic [5:0]  in_sv;
  logic [3:0]  in_fi;
  logic [15:0] in_value;
  logic [23:0] in_alpha;
  logic [15:0] in_beta;
  logic        in_acc;
  logic        wr_coord, wr_weight, wr_sample, start;

  assign in_sv    = in_tdata[5:0];
  assign in_fi    = in_tdata[9:6];
  assign in_value = in_tdata[25:10];
  assign in_alpha = in_tdata[49:26];
  assign in_beta  = in_tdata[65:50];
  assign in_acc   = in_tvalid && in_tready;

  always_comb begin
    wr_coord  = 1'b0;
    wr_weight = 1'b0;
    wr_sample = 1'b0;
    unique case (in_tuser)
      REQ_COORD:  wr_coord  = in_acc && (32'(in_sv) < MAX_VECTORS)
                              && (32'(in_fi) < MAX_FEATURES);
      REQ_WEIGHT: wr_weight = in_acc && (32'(in_sv) < MAX_VECTORS);
      REQ_SAMPLE: wr_sample = in_acc;
      default: ;
    endcase
  end
  assign start = wr_sample && in_tlast;

  // effective counts
  logic [NSW-1:0] nsv_eff;
  logic [DMW-1:0] dim_eff;
  assign nsv_eff = (32'(sv_count_r) > MAX_VECTORS) ? NSW'(MAX_VECTORS) : NSW'(sv_count_r);
  assign dim_eff = (32'(dim_r) > MAX_FEATURES) ? DMW'(MAX_FEATURES) : DMW'(dim_r);

  // sequencer and output control
  state_t         state_r;
  logic [VIW-1:0] i_r;
  logic [FIW-1:0] d_r;
  logic           issue, d_wrap, i_last;
  logic           zs_r;
  logic [31:0]    res_r;
  logic           res_sat_r;
  logic           out_v_r;
  logic [31:0]    out_data_r;
  logic           out_sat_r;
  logic           ld_out;
  logic           f2_v_r;
  logic [31:0]    res_nxt;
  logic           sat_nxt;

  assign issue     = (state_r == S_RUN);
  assign d_wrap    = (d_r == FIW'(MAX_FEATURES - 1));
  assign i_last    = (32'(i_r) + 1 == 32'(nsv_eff));
  assign in_tready = (state_r == S_IDLE);
  assign ld_out    = (state_r == S_HOLD) && (!out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      d_r     <= '0;
      zs_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      zs_r <= (state_r == S_IDLE) && start && (nsv_eff == '0);
      if (ld_out) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            i_r <= '0;
            d_r <= '0;
            if (nsv_eff == '0) begin
              state_r <= S_WAIT;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (d_wrap) begin
            d_r <= '0;
            if (i_last) begin
              state_r <= S_WAIT;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            d_r <= d_r + 1'b1;
          end
        end
        S_WAIT: begin
          if (f2_v_r) begin
            res_r     <= res_nxt;
            res_sat_r <= sat_nxt;
            state_r   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (ld_out) begin
            out_data_r <= res_r;
            out_sat_r  <= res_sat_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // sample ring: cell 0 shows feature d while the sequencer is at d
  logic [15:0] ring [MAX_FEATURES];

  for (genvar k = 0; k < MAX_FEATURES; k++) begin : g_ring
    rbfks_cell u_cell (
      .clk     (clk),
      .shift   (issue),
      .wr_en   (wr_sample && (32'(in_fi) == k)),
      .wr_data (in_value),
      .nb_data (ring[(k + 1) % MAX_FEATURES]),
      .value   (ring[k])
    );
  end

  // tables
  logic [15:0]          coord_mem  [CDEPTH];
  logic [WEIGHT_W-1:0]  weight_mem [MAX_VECTORS];
  logic [SCALE_W-1:0]   scale_mem  [MAX_VECTORS];
  logic [CAW-1:0]       coord_wa, coord_ra;
  logic [15:0]          coord_q;

  assign coord_wa = CAW'(32'(in_sv) * MAX_FEATURES + 32'(in_fi));
  assign coord_ra = CAW'(32'(i_r) * MAX_FEATURES + 32'(d_r));

  always_ff @(posedge clk) begin
    if (wr_coord) begin
      coord_mem[coord_wa] <= in_value;
    end
    coord_q <= coord_mem[coord_ra];
  end

  // distance pipeline
  logic           v0_r, v1_r, v2_r;
  logic           m0_r, m1_r;
  logic           l0_r, l1_r, l2_r;
  logic           lv0_r, lv1_r, lv2_r;
  logic [VIW-1:0] vi0_r, vi1_r, vi2_r;
  logic [15:0]    s0_r;
  logic signed [16:0] diff1_r;
  logic [31:0]    sq2_r;
  logic [D2_W-1:0] d2acc_r, d2_sum;
  rbfks_vec_t     kv_r;
  rbfks_sum_t     ks;

  assign d2_sum = d2acc_r + D2_W'(sq2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      kv_r.valid <= 1'b0;
      d2acc_r <= '0;
    end else begin
      v0_r <= issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      kv_r.valid <= v2_r && l2_r;
      if (v2_r) begin
        d2acc_r <= l2_r ? '0 : d2_sum;
      end
      kv_r.last   <= lv2_r;
      kv_r.d2     <= d2_sum;
      kv_r.scale  <= scale_mem[vi2_r];
      kv_r.weight <= $signed(weight_mem[vi2_r]);
    end
  end

  always_ff @(posedge clk) begin
    s0_r  <= ring[0];
    m0_r  <= (32'(d_r) < 32'(dim_eff));
    l0_r  <= d_wrap;
    lv0_r <= d_wrap && i_last;
    vi0_r <= i_r;

    diff1_r <= $signed({coord_q[15], coord_q}) - $signed({s0_r[15], s0_r});
    m1_r    <= m0_r;
    l1_r    <= l0_r;
    lv1_r   <= lv0_r;
    vi1_r   <= vi0_r;

    sq2_r <= m1_r ? 32'(34'(diff1_r) * 34'(diff1_r)) : 32'd0;
    l2_r  <= l1_r;
    lv2_r <= lv1_r;
    vi2_r <= vi1_r;

    if (wr_weight) begin
      weight_mem[VIW'(in_sv)] <= in_alpha;
      scale_mem[VIW'(in_sv)]  <= in_beta;
    end
  end

  rbfks_kernel #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_kernel (
    .clk   (clk),
    .rst_n (rst_n),
    .gamma (gamma_r),
    .vin   (kv_r),
    .sout  (ks)
  );

  // bias, sign and rounding to Q16.16
  logic                    f1_v_r;
  logic signed [ACC_W-1:0] x1_r, x2_r, x_rnd;
  logic signed [ACC_W-17:0] r_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= ks.done || zs_r;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= (ks.done ? ks.sum : '0) - (ACC_W'($signed(bias_r)) <<< 16);
    x2_r <= invert_r ? -x1_r : x1_r;
  end

  assign x_rnd = x2_r + ACC_W'(32768);
  assign r_q   = x_rnd[ACC_W-1:16];

  always_comb begin
    if (r_q > (ACC_W-16)'(64'sd2147483647)) begin
      res_nxt = 32'h7fff_ffff;
      sat_nxt = 1'b1;
    end else if (r_q < -((ACC_W-16)'(64'sd2147483648))) begin
      res_nxt = 32'h8000_0000;
      sat_nxt = 1'b1;
    end else begin
      res_nxt = r_q[31:0];
      sat_nxt = 1'b0;
    end
  end

  // a kernel sum only completes while the block waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ks.done |-> (state_r == S_WAIT))
    else $error("kernel sum outside wait state");

  // the ring stays aligned: feature counter is home outside a run
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> (d_r == '0))
    else $error("feature counter off home position");

  // a result never overwrites a beat the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |-> (!out_v_r || out_tready))
    else $error("result register overwritten");

endmodule

// File: src/rbfks_cell.sv
// one cell of the rotating sample feature ring
module rbfks_cell
  import rbfks_pkg::*;
(
  input  logic        clk,
  input  logic        shift,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  input  logic [15:0] nb_data,
  output logic [15:0] value
);

  logic [15:0] value_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_r <= wr_data;
    end else if (shift) begin
      value_r <= nb_data;
    end
  end

  assign value = value_r;

endmodule

// File: src/rbfks_kernel.sv
// kernel pipeline: distance to exp(-gamma*scale*d2), weighted and summed
module rbfks_kernel
  import rbfks_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [GAMMA_W-1:0] gamma,
  input  rbfks_vec_t         vin,
  output rbfks_sum_t         sout
);

  localparam int IW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int UDW = 20 + IW;

  function automatic logic [(EXP_TABLE_DEPTH+1)*EXP_W-1:0] build_exp();
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] v;
    logic signed [63:0] ratio;
    logic [(EXP_TABLE_DEPTH+1)*EXP_W-1:0] tab;
    y     = (64'd16 << 30) / EXP_TABLE_DEPTH;
    term  = 64'd1 << 30;
    ratio = 64'sd1 <<< 30;
    v     = 64'd1 << 30;
    tab   = '0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2 == 1) ratio = ratio - $signed(term);
      else            ratio = ratio + $signed(term);
    end
    if (ratio < 0) ratio = '0;
    for (int j = 0; j <= EXP_TABLE_DEPTH; j++) begin
      tab[j*EXP_W +: EXP_W] = EXP_W'((v + (64'd1 << 13)) >> 14);
      v = (v * $unsigned(ratio) + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam logic [(EXP_TABLE_DEPTH+1)*EXP_W-1:0] EXP_FLAT = build_exp();

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic l1_r, l2_r, l3_r, l4_r, l5_r, l6_r, l7_r, l8_r;
  logic signed [WEIGHT_W-1:0] w1_r, w2_r, w3_r, w4_r, w5_r, w6_r, w7_r;
  logic [31:0]       gs1_r;
  logic [D2_W-1:0]   d21_r;
  logic [50:0]       pl2_r, ph2_r;
  logic [51:0]       p_nxt;
  logic              z3_r, z4_r, z5_r, z6_r;
  logic [19:0]       u3_r;
  logic [UDW-1:0]    ud_nxt;
  logic [IW-1:0]     idx4_r;
  logic [FRAC_W-1:0] f4_r, f5_r;
  logic [EXP_W-1:0]  a5_r, b5_r, a6_r, k7_r;
  logic [36:0]       prod6_r;
  logic signed [41:0] wk8_r;
  logic signed [ACC_W-1:0] acc_r, sum_r;
  logic              done_r;

  assign p_nxt  = 52'(pl2_r) + (52'(ph2_r[24:0]) << 19);
  assign ud_nxt = UDW'(u3_r) * UDW'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r} <= '0;
      done_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      v1_r <= vin.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      done_r <= v8_r && l8_r;
      if (v8_r) begin
        if (l8_r) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_r + ACC_W'(wk8_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    l1_r  <= vin.last;
    gs1_r <= 32'(vin.scale) * 32'(gamma);
    d21_r <= vin.d2;
    w1_r  <= vin.weight;

    l2_r  <= l1_r;
    pl2_r <= 51'(gs1_r) * 51'(d21_r[18:0]);
    ph2_r <= 51'(gs1_r) * 51'(d21_r[37:19]);
    w2_r  <= w1_r;

    // past 2^44 the exponent is 16 or more and the kernel is zero
    l3_r <= l2_r;
    z3_r <= (ph2_r >= (51'd1 << 25)) || (p_nxt >= (52'd1 << 44));
    u3_r <= p_nxt[43:24];
    w3_r <= w2_r;

    l4_r   <= l3_r;
    idx4_r <= IW'(ud_nxt >> 20);
    f4_r   <= ud_nxt[19:0];
    z4_r   <= z3_r;
    w4_r   <= w3_r;

    l5_r <= l4_r;
    a5_r <= EXP_FLAT[32'(idx4_r)*EXP_W +: EXP_W];
    b5_r <= EXP_FLAT[(32'(idx4_r)+1)*EXP_W +: EXP_W];
    f5_r <= f4_r;
    z5_r <= z4_r;
    w5_r <= w4_r;

    l6_r    <= l5_r;
    prod6_r <= 37'(a5_r - b5_r) * 37'(f5_r);
    a6_r    <= a5_r;
    z6_r    <= z5_r;
    w6_r    <= w5_r;

    l7_r <= l6_r;
    k7_r <= z6_r ? '0 : a6_r - prod6_r[36:20];
    w7_r <= w6_r;

    l8_r  <= l7_r;
    wk8_r <= w7_r * $signed({1'b0, k7_r});

    if (v8_r && l8_r) begin
      sum_r <= acc_r + ACC_W'(wk8_r);
    end
  end

  assign sout.done = done_r;
  assign sout.sum  = sum_r;

endmodule

// File: bench/tb.sv
// testbench of the rbf kernel classifier score block: directed table, then random phases
module tb
  import rbfks_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVEC = 64;
  localparam int NFEAT = 16;
  localparam int EXP_STEPS = 256;
  localparam int ITEM_TARGET = 800;
  localparam int QUIET_AFTER = 650;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    rbfks_reg_t regsel;
    logic [31:0] wdata;
    logic [1:0] req;
    logic [5:0] sv;
    logic [3:0] fi;
    logic [15:0] val;
    logic [23:0] alpha;
    logic [15:0] beta;
    logic       last;
    logic       typed;
    logic [31:0] exp_score;
    logic       exp_sat;
  } stim_row_t;

  typedef struct {
    logic [31:0] score;
    logic        sat;
  } score_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  rbf_kernel_classifier_score_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] coord_mem [NVEC][NFEAT];
  logic signed [23:0] weight_mem [NVEC];
  logic [15:0]        scale_mem [NVEC];
  logic signed [15:0] sample_mem [NFEAT];
  bit                 coord_wr [NVEC][NFEAT];
  bit                 weight_wr [NVEC];
  bit                 sample_wr [NFEAT];
  longint unsigned    exp_lut [EXP_STEPS+1];
  logic [6:0]         sv_count_r;
  logic [4:0]         dim_r;
  logic [15:0]        gamma_r;
  logic signed [31:0] bias_r;
  logic               invert_r;

  score_beat_t score_q [$];
  int  errors = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  longint cycles = 0;
  int  stall_left = 0;

  function automatic void build_exp_lut();
    longint unsigned unit, y, term, v;
    longint ratio;
    unit = 64'd1 << 30;
    y = (64'd16 << 30) / EXP_STEPS;
    term = unit;
    ratio = unit;
    v = unit;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 30) / k;
      if (k % 2 == 1) ratio -= longint'(term);
      else ratio += longint'(term);
    end
    if (ratio < 0) ratio = 0;
    for (int k = 0; k <= EXP_STEPS; k++) begin
      exp_lut[k] = (v + (64'd1 << 13)) >> 14;
      v = (v * longint'(ratio) + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic longint unsigned rbf_kernel(int sv, int dim);
    longint unsigned d2, gs, u, idx, frac, a, b;
    longint df;
    d2 = 0;
    for (int d = 0; d < dim; d++) begin
      df = longint'(coord_mem[sv][d]) - longint'(sample_mem[d]);
      d2 += longint'(df * df);
    end
    gs = longint'(gamma_r) * longint'(scale_mem[sv]);
    if (gs != 0 && d2 > 64'hFFFF_FFFF_FFFF_FFFF / gs) return 0;
    u = (gs * d2) >> 24;
    if (u >= (64'd16 << 16)) return 0;
    u = u * EXP_STEPS;
    idx = u >> 20;
    frac = u & 64'hF_FFFF;
    a = exp_lut[idx];
    b = exp_lut[idx+1];
    return a - (((a - b) * frac) >> 20);
  endfunction

  // updates the state for one accepted beat, returns 1 when a score comes out
  function automatic bit predict_score(logic [1:0] req, int sv, int fi, logic [15:0] val,
                                       logic [23:0] alpha, logic [15:0] beta, logic last,
                                       output score_beat_t beat);
    longint acc, r;
    int nsv, dim;
    beat.score = '0;
    beat.sat = 1'b0;
    case (req)
      REQ_COORD: begin
        coord_mem[sv][fi] = val;
        coord_wr[sv][fi] = 1'b1;
        return 1'b0;
      end
      REQ_WEIGHT: begin
        weight_mem[sv] = alpha;
        scale_mem[sv] = beta;
        weight_wr[sv] = 1'b1;
        return 1'b0;
      end
      REQ_SAMPLE: begin
        sample_mem[fi] = val;
        sample_wr[fi] = 1'b1;
      end
      default: return 1'b0;
    endcase
    if (!last) return 1'b0;
    nsv = (sv_count_r > NVEC) ? NVEC : int'(sv_count_r);
    dim = (dim_r > NFEAT) ? NFEAT : int'(dim_r);
    acc = 0;
    for (int i = 0; i < nsv; i++)
      acc += longint'(weight_mem[i]) * longint'(rbf_kernel(i, dim));
    acc -= longint'(bias_r) * 65536;
    if (invert_r) acc = -acc;
    r = (acc + 32768) >>> 16;
    if (r > 64'sh7FFF_FFFF) begin
      r = 64'sh7FFF_FFFF;
      beat.sat = 1'b1;
    end
    if (r < -64'sh8000_0000) begin
      r = -64'sh8000_0000;
      beat.sat = 1'b1;
    end
    beat.score = r[31:0];
    return 1'b1;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // result side: random stall bursts, none in the last part
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    score_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (score_q.size() == 0) begin
        report($sformatf("score beat %h with none expected", out_tdata));
      end else begin
        want = score_q.pop_front();
        if (out_tdata !== want.score)
          report($sformatf("score %h, expected %h", out_tdata, want.score));
        if (out_tuser !== want.sat)
          report($sformatf("saturated %b, expected %b", out_tuser, want.sat));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] req, int sv, int fi, logic [15:0] val, logic [23:0] alpha,
                      logic [15:0] beta, logic last, logic typed = 1'b0,
                      logic [31:0] exp_score = '0, logic exp_sat = 1'b0);
    score_beat_t beat;
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tlast <= last;
    in_tdata <= {6'd0, beta, alpha, val, 4'(fi), 6'(sv)};
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    if (predict_score(req, sv, fi, val, alpha, beta, last, beat)) begin
      if (typed) begin
        beat.score = exp_score;
        beat.sat = exp_sat;
      end
      score_q.push_back(beat);
    end
    if (req != 2'd3) items_sent++;
    if (items_sent > QUIET_AFTER) quiet = 1'b1;
  endtask

  // lowers valid and waits until the block has delivered every score
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (score_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(rbfks_reg_t regsel, logic [31:0] data);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(regsel) << 2;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (regsel)
      REG_SV_COUNT: sv_count_r = data[6:0];
      REG_DIM:      dim_r = data[4:0];
      REG_GAMMA:    gamma_r = data[15:0];
      REG_BIAS:     bias_r = data;
      REG_INVERT:   invert_r = data[0];
      default: ;
    endcase
  endtask

  // mostly near the unit range so kernels land inside the table
  function automatic logic [15:0] rand_feature();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  function automatic logic [23:0] rand_alpha();
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 1 << 21) - (1 << 20));
  endfunction

  function automatic logic [15:0] rand_beta();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16384));
  endfunction

  task automatic load_vectors(int nsv, int dim);
    for (int i = 0; i < nsv; i++) begin
      for (int d = 0; d < dim; d++)
        if (!coord_wr[i][d]) send(REQ_COORD, i, d, rand_feature(), '0, '0, 1'($urandom));
      if (!weight_wr[i]) send(REQ_WEIGHT, i, 0, 16'($urandom), rand_alpha(), rand_beta(), 1'b0);
    end
  endtask

  task automatic noise();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      send(REQ_COORD, $urandom_range(0, 63), $urandom_range(0, 15), rand_feature(),
           24'($urandom), 16'($urandom), 1'($urandom));
    else if (pick < 7)
      send(REQ_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom),
           rand_alpha(), rand_beta(), 1'($urandom));
    else if (pick < 8)
      send(2'd3, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom),
           24'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // one sample: features for every used position, last on the final one;
  // sometimes only part of them, relying on the buffer keeping old features
  task automatic sample_run(int dim);
    int fis [$];
    bit partial;
    partial = ($urandom_range(0, 3) == 0);
    for (int d = 0; d < dim; d++)
      if (!(partial && sample_wr[d] && $urandom_range(0, 1) == 0)) fis.push_back(d);
    if ($urandom_range(0, 3) == 0) fis.push_back($urandom_range(0, 15));
    if (fis.size() == 0) fis.push_back($urandom_range(0, 15));
    foreach (fis[k]) begin
      if ($urandom_range(0, 5) == 0) noise();
      send(REQ_SAMPLE, $urandom_range(0, 63), fis[k], rand_feature(), 24'($urandom),
           16'($urandom), k == fis.size() - 1);
    end
  endtask

  task automatic run_phase(int sv_cnt, int dim, int gam, logic [31:0] bias, bit inv, int runs);
    int nsv, edim;
    cfg_write(REG_SV_COUNT, sv_cnt);
    cfg_write(REG_DIM, dim);
    cfg_write(REG_GAMMA, gam);
    cfg_write(REG_BIAS, bias);
    cfg_write(REG_INVERT, inv);
    nsv = (sv_cnt > NVEC) ? NVEC : sv_cnt;
    edim = (dim > NFEAT) ? NFEAT : dim;
    load_vectors(nsv, edim);
    for (int d = 0; d < edim; d++)
      if (!sample_wr[d]) send(REQ_SAMPLE, 0, d, rand_feature(), '0, '0, 1'b0);
    for (int r = 0; r < runs; r++) begin
      repeat ($urandom_range(0, 3)) noise();
      sample_run(edim);
    end
  endtask

  stim_row_t directed [$];

  function automatic stim_row_t cfg_row(rbfks_reg_t regsel, logic [31:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, regsel: regsel, wdata: data, req: '0, sv: '0, fi: '0, val: '0,
          alpha: '0, beta: '0, last: 1'b0, typed: 1'b0, exp_score: '0, exp_sat: 1'b0};
    return r;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] req, logic [5:0] sv, logic [3:0] fi,
                                         logic [15:0] val, logic [23:0] alpha,
                                         logic [15:0] beta, logic last, logic typed,
                                         logic [31:0] exp_score, logic exp_sat);
    stim_row_t r;
    r = '{kind: ROW_ITEM, regsel: REG_SV_COUNT, wdata: '0, req: req, sv: sv, fi: fi,
          val: val, alpha: alpha, beta: beta, last: last, typed: typed,
          exp_score: exp_score, exp_sat: exp_sat};
    return r;
  endfunction

  initial begin
    build_exp_lut();
    sv_count_r = 7'd0;
    dim_r = 5'd2;
    gamma_r = 16'd410;
    bias_r = '0;
    invert_r = 1'b0;

    // no vectors active after reset: the score is the negated bias, zero here
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd0, 16'h8000, '0, '0, 1'b1,
                                1'b1, 32'h0, 1'b0));
    directed.push_back(item_row(2'd3, 6'h3F, 4'hF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1,
                                1'b0, '0, 1'b0));
    directed.push_back(item_row(REQ_COORD, 6'd0, 4'd0, 16'h7FFF, '0, '0, 1'b1,
                                1'b0, '0, 1'b0));
    directed.push_back(item_row(REQ_COORD, 6'h3F, 4'hF, 16'h8000, 24'hFFFFFF, 16'hFFFF, 1'b0,
                                1'b0, '0, 1'b0));
    directed.push_back(item_row(REQ_WEIGHT, 6'h3F, 4'hF, 16'hFFFF, 24'h800000, 16'hFFFF,
                                1'b1, 1'b0, '0, 1'b0));
    directed.push_back(item_row(REQ_WEIGHT, 6'd0, 4'd0, 16'h0, 24'h7FFFFF, 16'h0, 1'b0,
                                1'b0, '0, 1'b0));
    directed.push_back(cfg_row(REG_BIAS, 32'h8000_0000));
    directed.push_back(item_row(REQ_SAMPLE, 6'h3F, 4'hF, 16'h7FFF, '0, '0, 1'b1,
                                1'b1, 32'h7FFF_FFFF, 1'b1));
    directed.push_back(cfg_row(REG_INVERT, 32'd1));
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd1, 16'h0001, '0, '0, 1'b1,
                                1'b1, 32'h8000_0000, 1'b0));
    directed.push_back(cfg_row(REG_BIAS, 32'h7FFF_FFFF));
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd0, 16'h0100, '0, '0, 1'b1,
                                1'b1, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(cfg_row(REG_INVERT, 32'd0));
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd0, 16'h0100, '0, '0, 1'b1,
                                1'b1, 32'h8000_0001, 1'b0));
    directed.push_back(cfg_row(REG_BIAS, 32'h0001_0000));
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd0, 16'hFF00, '0, '0, 1'b1,
                                1'b1, 32'hFFFF_0000, 1'b0));
    // one vector, one feature, gamma zero: kernel is exactly one
    directed.push_back(cfg_row(REG_SV_COUNT, 32'd1));
    directed.push_back(cfg_row(REG_DIM, 32'd1));
    directed.push_back(cfg_row(REG_GAMMA, 32'd0));
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd0, 16'h0080, '0, '0, 1'b1,
                                1'b0, '0, 1'b0));
    directed.push_back(cfg_row(REG_GAMMA, 32'd410));
    directed.push_back(item_row(REQ_SAMPLE, 6'd0, 4'd0, 16'h7F00, '0, '0, 1'b1,
                                1'b0, '0, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CFG)
        cfg_write(directed[k].regsel, directed[k].wdata);
      else
        send(directed[k].req, directed[k].sv, directed[k].fi, directed[k].val,
             directed[k].alpha, directed[k].beta, directed[k].last, directed[k].typed,
             directed[k].exp_score, directed[k].exp_sat);
    end

    // extremes of the registers first, then random settings
    run_phase(64, 1, 410, 32'h0, 1'b0, 3);
    run_phase(127, 1, 65535, 32'hFFFF_0000, 1'b1, 2);
    run_phase(4, 16, 0, 32'h7FFF_FFFF, 1'b0, 3);
    run_phase(3, 31, 1000, 32'h8000_0000, 1'b1, 3);
    run_phase(5, 0, 2000, 32'h0002_0000, 1'b0, 3);
    while (items_sent < ITEM_TARGET) begin
      run_phase($urandom_range(0, 8), $urandom_range(1, 16),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2048),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 21) - (1 << 20),
                1'($urandom), $urandom_range(3, 8));
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
